>>> src/sseq_pkg.sv
// Shared constants, codes and controller-to-datapath command type for the sorted event queue.
`timescale 1ns / 1ps
`default_nettype none

package sseq_pkg;

   localparam int DEPTH       = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int TAG_WIDTH   = 16;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Operation codes carried on the cmd field.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Command from the controller to the datapath for one accepted word.
   typedef struct packed {
      logic                   load;       // a word is accepted this cycle
      logic                   do_insert;  // insert goes into the cell row
      logic                   do_remove;  // front cell leaves, the row shifts down
      logic [COUNT_WIDTH-1:0] count;      // entries held before this word
   } dp_cmd_type;

endpackage

`default_nettype wire

>>> src/sseq_ctrl.sv
// Controller of the sorted event queue: handshake, entry count and status.
`timescale 1ns / 1ps
`default_nettype none

module sseq_ctrl (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_cmd,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [sseq_pkg::COUNT_WIDTH-1:0]     rsp_entry_count,
   output logic [1:0]                           rsp_status,
   output sseq_pkg::dp_cmd_type                 dp_cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_HOLD
   } state_type;

   state_type                          state_ff, state_in;
   logic [sseq_pkg::COUNT_WIDTH-1:0]   count_ff, count_in;
   sseq_pkg::status_type               status_ff, status_in;
   logic                               accept;
   logic                               is_full;
   logic                               is_empty;

   assign req_ready = (state_ff == ST_IDLE) || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == sseq_pkg::COUNT_WIDTH'(sseq_pkg::DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      status_in = status_ff;
      dp_cmd.load      = accept;
      dp_cmd.do_insert = 1'b0;
      dp_cmd.do_remove = 1'b0;
      dp_cmd.count     = count_ff;
      unique case (state_ff)
         ST_IDLE, ST_HOLD: begin
            if (accept) begin
               state_in = ST_HOLD;
               if (req_cmd == sseq_pkg::CMD_INSERT) begin
                  if (is_full) begin
                     status_in = sseq_pkg::STATUS_FULL;
                  end else begin
                     status_in        = sseq_pkg::STATUS_OK;
                     dp_cmd.do_insert = 1'b1;
                     count_in         = count_ff + 1'b1;
                  end
               end else begin
                  if (is_empty) begin
                     status_in = sseq_pkg::STATUS_EMPTY;
                  end else begin
                     status_in        = sseq_pkg::STATUS_OK;
                     dp_cmd.do_remove = 1'b1;
                     count_in         = count_ff - 1'b1;
                  end
               end
            end else if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         status_ff <= sseq_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid       = (state_ff == ST_HOLD);
   assign rsp_entry_count = count_ff;
   assign rsp_status      = status_ff;

endmodule

`default_nettype wire

>>> src/sseq_datapath.sv
// Datapath of the sorted event queue: the row of sorted cells and the removed-entry register.
`timescale 1ns / 1ps
`default_nettype none

module sseq_datapath (
   input  wire logic                              clock,
   input  wire sseq_pkg::dp_cmd_type              dp_cmd,
   input  wire logic [sseq_pkg::TIME_WIDTH-1:0]   req_item_time,
   input  wire logic [sseq_pkg::TAG_WIDTH-1:0]    req_item_tag,
   output logic                                   rsp_removed_valid,
   output logic [sseq_pkg::TIME_WIDTH-1:0]        rsp_removed_time,
   output logic [sseq_pkg::TAG_WIDTH-1:0]         rsp_removed_tag,
   output logic [sseq_pkg::TIME_WIDTH-1:0]        rsp_front_time,
   output logic [sseq_pkg::TAG_WIDTH-1:0]         rsp_front_tag
);

   logic [sseq_pkg::TIME_WIDTH-1:0] cell_time_ff [sseq_pkg::DEPTH];
   logic [sseq_pkg::TAG_WIDTH-1:0]  cell_tag_ff  [sseq_pkg::DEPTH];
   logic [sseq_pkg::DEPTH-1:0]      after_new;
   logic                            removed_valid_ff;
   logic [sseq_pkg::TIME_WIDTH-1:0] removed_time_ff;
   logic [sseq_pkg::TAG_WIDTH-1:0]  removed_tag_ff;

   // A cell moves behind the new entry when it is empty or strictly later,
   // which keeps entries with equal times in arrival order.
   always_comb begin
      for (int i = 0; i < sseq_pkg::DEPTH; i++) begin
         after_new[i] = (sseq_pkg::COUNT_WIDTH'(i) >= dp_cmd.count) ||
                        (cell_time_ff[i] > req_item_time);
      end
   end

   for (genvar g = 0; g < sseq_pkg::DEPTH; g++) begin : g_cell
      always_ff @(posedge clock) begin
         if (dp_cmd.do_insert && after_new[g]) begin
            if (g == 0) begin
               cell_time_ff[g] <= req_item_time;
               cell_tag_ff[g]  <= req_item_tag;
            end else if (!after_new[(g == 0) ? 0 : g - 1]) begin
               cell_time_ff[g] <= req_item_time;
               cell_tag_ff[g]  <= req_item_tag;
            end else begin
               cell_time_ff[g] <= cell_time_ff[(g == 0) ? 0 : g - 1];
               cell_tag_ff[g]  <= cell_tag_ff[(g == 0) ? 0 : g - 1];
            end
         end else if (dp_cmd.do_remove && (g != sseq_pkg::DEPTH - 1)) begin
            cell_time_ff[g] <= cell_time_ff[(g == sseq_pkg::DEPTH - 1) ? g : g + 1];
            cell_tag_ff[g]  <= cell_tag_ff[(g == sseq_pkg::DEPTH - 1) ? g : g + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         removed_valid_ff <= dp_cmd.do_remove;
         removed_time_ff  <= dp_cmd.do_remove ? cell_time_ff[0] : '0;
         removed_tag_ff   <= dp_cmd.do_remove ? cell_tag_ff[0] : '0;
      end
   end

   assign rsp_removed_valid = removed_valid_ff;
   assign rsp_removed_time  = removed_time_ff;
   assign rsp_removed_tag   = removed_tag_ff;
   assign rsp_front_time    = cell_time_ff[0];
   assign rsp_front_tag     = cell_tag_ff[0];

endmodule

`default_nettype wire

>>> src/stable_sorted_event_queue.sv
// Top level of the stable sorted event queue: controller and cell-row datapath.
`timescale 1ns / 1ps
`default_nettype none

// The queue holds up to DEPTH entries, each a time key and a tag, in a row of
// cells kept in ascending time order; an insert lands behind every entry whose
// time is less than or equal to its own, so equal times leave in arrival order.
// Each request word is an insert or a remove of the earliest entry, and each
// gives exactly one response word: the removed entry (if any), the front entry,
// the count after the step and a status (full insert and empty remove are
// dropped and flagged). A request is taken and its response appears in the
// response register on the next cycle; all cells compare against the new key
// and shift at once, so one word per cycle is sustained as long as responses
// are taken. req_ready is high whenever the response register is empty or
// is being drained in the same cycle. Front fields read zero when the queue
// is empty; removed fields read zero when no entry was removed.
module stable_sorted_event_queue (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_cmd,
   input  wire logic [sseq_pkg::TIME_WIDTH-1:0]   req_item_time,
   input  wire logic [sseq_pkg::TAG_WIDTH-1:0]    req_item_tag,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_removed_valid,
   output logic [sseq_pkg::TIME_WIDTH-1:0]        rsp_removed_time,
   output logic [sseq_pkg::TAG_WIDTH-1:0]         rsp_removed_tag,
   output logic                                   rsp_front_valid,
   output logic [sseq_pkg::TIME_WIDTH-1:0]        rsp_front_time,
   output logic [sseq_pkg::TAG_WIDTH-1:0]         rsp_front_tag,
   output logic [sseq_pkg::COUNT_WIDTH-1:0]       rsp_entry_count,
   output logic [1:0]                             rsp_status
);

   sseq_pkg::dp_cmd_type            dp_cmd;
   logic [sseq_pkg::TIME_WIDTH-1:0] front_time_raw;
   logic [sseq_pkg::TAG_WIDTH-1:0]  front_tag_raw;

   sseq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status),
      .dp_cmd          (dp_cmd)
   );

   sseq_datapath u_datapath (
      .clock             (clock),
      .dp_cmd            (dp_cmd),
      .req_item_time     (req_item_time),
      .req_item_tag      (req_item_tag),
      .rsp_removed_valid (rsp_removed_valid),
      .rsp_removed_time  (rsp_removed_time),
      .rsp_removed_tag   (rsp_removed_tag),
      .rsp_front_time    (front_time_raw),
      .rsp_front_tag     (front_tag_raw)
   );

   // The front cell holds a real entry only while the count is nonzero;
   // an empty queue reports zero front fields.
   assign rsp_front_valid = (rsp_entry_count != '0);
   assign rsp_front_time  = rsp_front_valid ? front_time_raw : '0;
   assign rsp_front_tag   = rsp_front_valid ? front_tag_raw : '0;

endmodule

`default_nettype wire

>>> src/sseq_checker.sv
// Port-level assertions for the sorted event queue and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sseq_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             req_cmd,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic                             rsp_removed_valid,
   input wire logic                             rsp_front_valid,
   input wire logic [sseq_pkg::COUNT_WIDTH-1:0] rsp_entry_count,
   input wire logic [1:0]                       rsp_status
);

   // A stalled response word holds its count and status.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry_count) && $stable(rsp_status))
      else $error("response word changed while stalled");

   // The front is valid exactly when the queue holds entries.
   a_front_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_front_valid == (rsp_entry_count != '0)))
      else $error("front valid disagrees with count");

   // A removed entry only comes with an ok status.
   a_removed_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removed_valid |-> rsp_status == sseq_pkg::STATUS_OK)
      else $error("removed entry with error status");

   // The count never passes the queue depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_entry_count <= sseq_pkg::COUNT_WIDTH'(sseq_pkg::DEPTH))
      else $error("entry count beyond depth");

   // An accepted remove answers with an entry or with the empty status.
   a_remove_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == sseq_pkg::CMD_REMOVE |=>
         rsp_valid && (rsp_removed_valid || rsp_status == sseq_pkg::STATUS_EMPTY))
      else $error("remove gave neither entry nor empty status");

endmodule

bind stable_sorted_event_queue sseq_checker u_sseq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_cmd           (req_cmd),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_removed_valid (rsp_removed_valid),
   .rsp_front_valid   (rsp_front_valid),
   .rsp_entry_count   (rsp_entry_count),
   .rsp_status        (rsp_status)
);

`default_nettype wire
